/* rtl/cht_pkg.sv */
// ---------------------------------------------------------------------------
// cht_pkg
// Shared sizes, codes and request types for the chained hash table.
// ---------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  localparam int BUCKETS = 127;
  localparam int ENTRIES = 256;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NODE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LINK_W = $clog2(ENTRIES + 1);
  localparam int CNT_W  = LINK_W;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

  // key mod BUCKETS through an exact reciprocal multiply
  localparam int RECIP_W = KEY_W + 1;
  localparam int SHIFT   = KEY_W + BKT_W;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [LINK_W-1:0] next;
  } node_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             clr;
    logic [BKT_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } head_req_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [NODE_W-1:0] addr;
    node_t             wdata;
  } pool_req_t;

endpackage

`default_nettype wire

/* rtl/cht_hash.sv */
// ---------------------------------------------------------------------------
// cht_hash
// Three-stage bucket index unit: key mod BUCKETS by reciprocal multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_hash
  import cht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  output logic                  bkt_vld,
  output logic [BKT_W-1:0]      bkt
);

  logic              v1_r, v2_r, v3_r;
  logic [KEY_W-1:0]  key1_r, key2_r;
  logic [PROD_W-1:0] prod_r;
  logic [KEY_W-1:0]  qb_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [QUOT_W-1:0] quot;
  logic [63:0]       qb_full;

  assign quot    = prod_r[PROD_W-1:SHIFT];
  assign qb_full = 64'(quot) * 64'(BUCKETS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key1_r <= key;
      prod_r <= PROD_W'(key) * PROD_W'(RECIP);
    end
    if (v1_r) begin
      key2_r <= key1_r;
      qb_r   <= qb_full[KEY_W-1:0];
    end
    if (v2_r) begin
      bkt_r <= BKT_W'(key2_r - qb_r);
    end
  end

  assign bkt_vld = v3_r;
  assign bkt     = bkt_r;

endmodule

`default_nettype wire

/* rtl/cht_heads.sv */
// ---------------------------------------------------------------------------
// cht_heads
// Bucket head memory with per-bucket valid bits; an invalid bucket is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_heads
  import cht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire head_req_t req,
  output logic [LINK_W-1:0] head
);

  logic [NODE_W-1:0]  mem [BUCKETS];
  logic [BUCKETS-1:0] vld_r;
  logic [NODE_W-1:0]  rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign head = rd_vld_r ? LINK_W'(rd_data_r) : NULL_LINK;

endmodule

`default_nettype wire

/* rtl/cht_pool.sv */
// ---------------------------------------------------------------------------
// cht_pool
// Node pool memory holding key, value and chain link of each node.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_pool
  import cht_pkg::*;
(
  input  wire logic      clk,
  input  wire pool_req_t req,
  output node_t          rd_node
);

  node_t mem [ENTRIES];
  node_t rd_node_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_node_r <= mem[req.addr];
    end
  end

  assign rd_node = rd_node_r;

endmodule

`default_nettype wire

/* rtl/chained_hash_table.sv */
// Insert and find pass through the hash unit and a bucket head read; find
// then walks the chain node by node, and clear goes straight to the result.
// One request at a time; the next is accepted the cycle after the result
// is registered. The chain walk reads one pool node per cycle and sets the
// find latency. Reset empties all buckets and the pool at once; no clearing
// pass.
// ---------------------------------------------------------------------------
// chained_hash_table
// Key-value table with separate chaining over a sequential node pool.
// ---------------------------------------------------------------------------
`default_nettype none

module chained_hash_table
  import cht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_opcode,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [VAL_W-1:0]  in_payload,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [VAL_W-1:0]       out_found_value,
  output logic [CNT_W-1:0]       out_entry_count
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  pay_r, pay_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              hash_start;
  logic              bkt_vld;
  logic [BKT_W-1:0]  bkt;
  head_req_t         head_req;
  logic [LINK_W-1:0] head;
  pool_req_t         pool_req;
  node_t             rd_node;
  logic [CNT_W-1:0]  steps_inc;

  cht_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key     (in_key),
    .bkt_vld (bkt_vld),
    .bkt     (bkt)
  );

  cht_heads u_heads (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (head_req),
    .head  (head)
  );

  cht_pool u_pool (
    .clk     (clk),
    .req     (pool_req),
    .rd_node (rd_node)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign steps_inc = steps_r + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    steps_nxt      = steps_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    hash_start     = 1'b0;
    head_req       = '0;
    pool_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          key_nxt        = in_key;
          pay_nxt        = in_payload;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          case (in_opcode)
            OP_INSERT, OP_FIND: begin
              hash_start = 1'b1;
              state_nxt  = S_HASH;
            end
            OP_CLEAR: begin
              head_req.clr = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_HASH: begin
        if (bkt_vld) begin
          head_req.rd   = 1'b1;
          head_req.addr = bkt;
          state_nxt     = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_FIN;
        if (op_r == OP_INSERT) begin
          if (cnt_r == CNT_W'(ENTRIES)) begin
            res_status_nxt = ST_FULL;
          end else begin
            pool_req.wr         = 1'b1;
            pool_req.addr       = NODE_W'(cnt_r);
            pool_req.wdata.key  = key_r;
            pool_req.wdata.value = pay_r;
            pool_req.wdata.next = head;
            head_req.wr         = 1'b1;
            head_req.addr       = bkt;
            head_req.wdata      = NODE_W'(cnt_r);
            cnt_nxt             = cnt_r + CNT_W'(1);
          end
        end else begin
          steps_nxt = '0;
          if (head >= NULL_LINK) begin
            res_status_nxt = ST_MISS;
          end else begin
            pool_req.rd   = 1'b1;
            pool_req.addr = NODE_W'(head);
            state_nxt     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_node.key == key_r) begin
          res_status_nxt = ST_OK;
          res_value_nxt  = rd_node.value;
          state_nxt      = S_FIN;
        end else begin
          steps_nxt = steps_inc;
          if (rd_node.next >= NULL_LINK || steps_inc >= CNT_W'(ENTRIES)) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_FIN;
          end else begin
            pool_req.rd   = 1'b1;
            pool_req.addr = NODE_W'(rd_node.next);
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire
